>>> hw/rtl/wtci_pkg.sv
`timescale 1ns / 1ps
// wtci_pkg: constants, payload types and func codes of the wavetable cubic lookup
// depends on nothing; imported by the channel interfaces, wtci_fetch, wtci_eval and the top

package wtci_pkg;

  // table geometry (depth is a power of two)
  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int unsigned N_BANKS     = 4;
  localparam int unsigned BANK_SEL_W  = $clog2(N_BANKS);
  localparam int unsigned BANK_DEPTH  = TABLE_DEPTH / N_BANKS;

  // payload widths
  localparam int unsigned SAMPLE_W    = 24;
  localparam int unsigned PHASE_W     = 32;
  localparam int unsigned ENTRY_IDX_W = 10;
  localparam int unsigned CFG_W       = 4;
  localparam int unsigned KSH_W       = $clog2(PHASE_W) + 1;

  // interpolation fraction and datapath widths
  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned ACC_W       = 30;
  localparam int unsigned PROD_W      = ACC_W + FRAC_BITS + 1;

  // table length limits, log2
  localparam int unsigned L_MIN       = 2;
  localparam int unsigned L_MAX       = ADDR_W;
  localparam int unsigned CFG_RESET   = 10;

  // func codes
  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [ACC_W-1:0]    acc_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [ACC_W:0]      wide_t;

  // rounding constant and output saturation limits
  localparam prod_t RND_HALF = PROD_W'(1 << (FRAC_BITS - 1));
  localparam wide_t SAT_MAX  = (ACC_W+1)'((2 ** (SAMPLE_W - 1)) - 1);
  localparam wide_t SAT_MIN  = (ACC_W+1)'(-(2 ** (SAMPLE_W - 1)));

  // four fetched taps in bank order, plus what the evaluator needs to sort them
  typedef struct packed {
    logic [N_BANKS-1:0][SAMPLE_W-1:0] tap;
    logic [BANK_SEL_W-1:0]            klo;
    logic [FRAC_BITS-1:0]             frac;
    logic                             block_end;
  } tap_set_t;

endpackage

>>> hw/rtl/wtci_req_if.sv
`timescale 1ns / 1ps
// wtci_req_if: input channel of the wavetable lookup, valid/ready plus item fields
// depends on wtci_pkg

interface wtci_req_if;
  import wtci_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   func;
  logic [ENTRY_IDX_W-1:0] entry_index;
  logic signed [SAMPLE_W-1:0] entry_value;
  logic [PHASE_W-1:0]     phase;
  logic                   block_end;

  modport source (output valid, func, entry_index, entry_value, phase, block_end,
                  input ready);
  modport sink   (input valid, func, entry_index, entry_value, phase, block_end,
                  output ready);
endinterface

>>> hw/rtl/wtci_rsp_if.sv
`timescale 1ns / 1ps
// wtci_rsp_if: result channel of the wavetable lookup, valid/ready plus result fields
// depends on wtci_pkg

interface wtci_rsp_if;
  import wtci_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic                       block_end_out;

  modport source (output valid, sample_out, block_end_out, input ready);
  modport sink   (input valid, sample_out, block_end_out, output ready);
endinterface

>>> hw/rtl/wtci_ram.sv
`timescale 1ns / 1ps
// wtci_ram: generic single-write, single-read RAM with registered read data
// depends on nothing

module wtci_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data held while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/wtci_fetch.sv
`timescale 1ns / 1ps
// wtci_fetch: length register, phase decode and the four-bank table store
// depends on wtci_pkg, wtci_req_if and wtci_ram; feeds wtci_eval with tap sets

module wtci_fetch (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [wtci_pkg::CFG_W-1:0] cfg_wdata_i,
  wtci_req_if.sink                 req_i,
  output logic                     tap_valid_o,
  input  logic                     tap_ready_i,
  output wtci_pkg::tap_set_t       taps_o
);
  import wtci_pkg::*;

  logic [CFG_W-1:0]       l_q, l_d;
  logic                   v1_q;
  logic [BANK_SEL_W-1:0]  klo_q;
  logic [FRAC_BITS-1:0]   frac_q;
  logic                   be_q;

  logic                   advance;
  logic                   accept;
  logic                   rd_en;
  logic                   wr_en;
  logic [KSH_W-1:0]       k_shift;
  logic [PHASE_W-1:0]     k_full;
  logic [PHASE_W-1:0]     frac_full;
  logic [ADDR_W-1:0]      k;
  logic [ADDR_W:0]        one_sh;
  logic [ADDR_W-1:0]      mask;
  logic [FRAC_BITS-1:0]   frac;
  logic [N_BANKS-1:0][ADDR_W-BANK_SEL_W-1:0] bank_raddr;
  logic [N_BANKS-1:0][SAMPLE_W-1:0]          bank_rdata;

  // length register, clamped to the supported range on write
  always_comb begin
    if (cfg_wdata_i < CFG_W'(L_MIN)) begin
      l_d = CFG_W'(L_MIN);
    end else if (cfg_wdata_i > CFG_W'(L_MAX)) begin
      l_d = CFG_W'(L_MAX);
    end else begin
      l_d = cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l_q <= CFG_W'(CFG_RESET);
    end else if (cfg_we_i) begin
      l_q <= l_d;
    end
  end

  // handshake: stage 1 moves when empty or taken downstream
  assign advance     = !v1_q || tap_ready_i;
  assign req_i.ready = advance;
  assign accept      = req_i.valid && advance;
  assign rd_en       = accept && (req_i.func == FUNC_LOOKUP);
  assign wr_en       = accept && (req_i.func == FUNC_WRITE);

  // phase decode: index from the top bits, fraction from the bits below
  assign k_shift   = KSH_W'(PHASE_W) - KSH_W'(l_q);
  assign k_full    = req_i.phase >> k_shift;
  assign k         = k_full[ADDR_W-1:0];
  assign frac_full = req_i.phase << l_q;
  assign frac      = frac_full[PHASE_W-1 -: FRAC_BITS];
  assign one_sh    = (ADDR_W+1)'(1) << l_q;
  assign mask      = one_sh[ADDR_W-1:0] - ADDR_W'(1);

  // neighbors k-1..k+2 land in four distinct banks
  always_comb begin
    logic [ADDR_W-1:0] nbr;
    bank_raddr = '0;
    for (int j = 0; j < N_BANKS; j++) begin
      nbr = (k + ADDR_W'(j) - ADDR_W'(1)) & mask;
      bank_raddr[nbr[BANK_SEL_W-1:0]] = nbr[ADDR_W-1:BANK_SEL_W];
    end
  end

  // table banks, interleaved on the low address bits
  for (genvar b = 0; b < N_BANKS; b++) begin : g_bank
    wtci_ram #(
      .WIDTH(SAMPLE_W),
      .DEPTH(BANK_DEPTH)
    ) u_bank (
      .clk_i  (clk_i),
      .we_i   (wr_en && (req_i.entry_index[BANK_SEL_W-1:0] == BANK_SEL_W'(b))),
      .waddr_i(req_i.entry_index[ADDR_W-1:BANK_SEL_W]),
      .wdata_i(req_i.entry_value),
      .re_i   (rd_en),
      .raddr_i(bank_raddr[b]),
      .rdata_o(bank_rdata[b])
    );
  end

  // stage 1 control and side data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (advance) begin
      v1_q <= rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      klo_q  <= k[BANK_SEL_W-1:0];
      frac_q <= frac;
      be_q   <= req_i.block_end;
    end
  end

  assign tap_valid_o      = v1_q;
  assign taps_o.tap       = bank_rdata;
  assign taps_o.klo       = klo_q;
  assign taps_o.frac      = frac_q;
  assign taps_o.block_end = be_q;

  // a lookup transfer always fills stage 1
  a_lookup_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |=> v1_q)
    else $error("lookup transfer did not reach stage 1");

  // stalled stage 1 keeps its read data
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && !tap_ready_i) |=> (v1_q && $stable(bank_rdata)))
    else $error("bank read data changed during stall");

  // length register stays in range
  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (l_q >= CFG_W'(L_MIN)) && (l_q <= CFG_W'(L_MAX)))
    else $error("table length out of range");

endmodule

>>> hw/rtl/wtci_eval.sv
`timescale 1ns / 1ps
// wtci_eval: coefficient stage, three Horner steps and rounding/saturation
// depends on wtci_pkg and wtci_rsp_if; takes tap sets from wtci_fetch

module wtci_eval (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               tap_valid_i,
  output logic               tap_ready_o,
  input  wtci_pkg::tap_set_t taps_i,
  wtci_rsp_if.source         rsp_o
);
  import wtci_pkg::*;

  function automatic acc_t sx(input logic [SAMPLE_W-1:0] s);
    return {{(ACC_W-SAMPLE_W){s[SAMPLE_W-1]}}, s};
  endfunction

  function automatic prod_t mul_frac(input acc_t a, input logic [FRAC_BITS-1:0] p);
    return a * $signed({1'b0, p});
  endfunction

  // floor((prod + half) / 2^FRAC_BITS) + d
  function automatic acc_t round_add(input prod_t prod, input acc_t d);
    prod_t t;
    t = (prod + RND_HALF) >>> FRAC_BITS;
    return acc_t'(ACC_W'(t)) + d;
  endfunction

  logic v2_q, v3_q, v4_q, v5_q, v6_q;
  logic en2, en3, en4, en5, en6;

  acc_t d0_d, d1_d, d2_d, d3_d;
  acc_t d0_q, d1_q, d2_q, d3_q;
  acc_t d0_3q, d1_3q, d2_3q;
  acc_t d0_4q, d1_4q;
  acc_t d0_5q;
  logic [FRAC_BITS-1:0] p2_q, p3_q, p4_q;
  logic be2_q, be3_q, be4_q, be5_q, be6_q;
  prod_t prod3_q, prod2_q, prod1_q;
  acc_t acc1, acc2, acc3;
  wide_t ysum, yval;
  sample_t y_d, y_q;

  // stage enables, each stage moves when empty or its successor moves
  assign en6         = !v6_q || rsp_o.ready;
  assign en5         = !v5_q || en6;
  assign en4         = !v4_q || en5;
  assign en3         = !v3_q || en4;
  assign en2         = !v2_q || en3;
  assign tap_ready_o = en2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (en2) v2_q <= tap_valid_i;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
      if (en6) v6_q <= v5_q;
    end
  end

  // sort the banked taps into k-1..k+2 and form the doubled coefficients
  always_comb begin
    logic [BANK_SEL_W-1:0] sel;
    acc_t a [N_BANKS];
    acc_t dif;
    for (int j = 0; j < N_BANKS; j++) begin
      sel  = taps_i.klo + BANK_SEL_W'(j) - BANK_SEL_W'(1);
      a[j] = sx(taps_i.tap[sel]);
    end
    dif  = a[1] - a[2];
    d0_d = a[1] <<< 1;
    d1_d = a[2] - a[0];
    d2_d = (a[0] <<< 1) - ((a[1] <<< 2) + a[1]) + (a[2] <<< 2) - a[3];
    d3_d = a[3] - a[0] + (dif <<< 1) + dif;
  end

  // stage 2: coefficients
  always_ff @(posedge clk_i) begin
    if (en2) begin
      d0_q  <= d0_d;
      d1_q  <= d1_d;
      d2_q  <= d2_d;
      d3_q  <= d3_d;
      p2_q  <= taps_i.frac;
      be2_q <= taps_i.block_end;
    end
  end

  // stage 3: leading product
  always_ff @(posedge clk_i) begin
    if (en3) begin
      prod3_q <= mul_frac(d3_q, p2_q);
      d0_3q   <= d0_q;
      d1_3q   <= d1_q;
      d2_3q   <= d2_q;
      p3_q    <= p2_q;
      be3_q   <= be2_q;
    end
  end

  // stage 4: first Horner step and next product
  assign acc1 = round_add(prod3_q, d2_3q);

  always_ff @(posedge clk_i) begin
    if (en4) begin
      prod2_q <= mul_frac(acc1, p3_q);
      d0_4q   <= d0_3q;
      d1_4q   <= d1_3q;
      p4_q    <= p3_q;
      be4_q   <= be3_q;
    end
  end

  // stage 5: second Horner step and last product
  assign acc2 = round_add(prod2_q, d1_4q);

  always_ff @(posedge clk_i) begin
    if (en5) begin
      prod1_q <= mul_frac(acc2, p4_q);
      d0_5q   <= d0_4q;
      be5_q   <= be4_q;
    end
  end

  // stage 6: last step, halve with rounding, saturate
  assign acc3 = round_add(prod1_q, d0_5q);
  assign ysum = wide_t'((ACC_W+1)'(acc3)) + wide_t'(1);
  assign yval = ysum >>> 1;

  always_comb begin
    if (yval > SAT_MAX) begin
      y_d = sample_t'(SAT_MAX[SAMPLE_W-1:0]);
    end else if (yval < SAT_MIN) begin
      y_d = sample_t'(SAT_MIN[SAMPLE_W-1:0]);
    end else begin
      y_d = sample_t'(yval[SAMPLE_W-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en6) begin
      y_q   <= y_d;
      be6_q <= be5_q;
    end
  end

  assign rsp_o.valid         = v6_q;
  assign rsp_o.sample_out    = y_q;
  assign rsp_o.block_end_out = be6_q;

  // a stalled product stage keeps its item
  a_prod_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && !en4) |=> (v3_q && $stable(prod3_q)))
    else $error("stage 3 item lost during stall");

  // an item leaving the last Horner stage reaches the output register
  a_reaches_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v5_q && en6) |=> v6_q)
    else $error("item dropped before output register");

endmodule

>>> hw/rtl/wavetable_cubic_interp_lookup_top.sv
`timescale 1ns / 1ps
// wavetable_cubic_interp_lookup_top: wavetable store with Catmull-Rom cubic lookup
// depends on wtci_pkg, wtci_req_if, wtci_rsp_if, wtci_fetch and wtci_eval
//
// Usage:
//   req_i carries one item per transfer. func = write stores entry_value at
//   entry_index and gives no result; func = lookup reads the four neighbors of
//   the index taken from the top bits of phase and interpolates with the next
//   16 bits as fraction. rsp_o carries one sample_out plus block_end_out per
//   lookup, in order.
//   cfg_we_i/cfg_wdata_i set the table length log2 (clamped to 2..10). The user
//   must write it only while no lookup is in flight (not enforced). Reset sets it to 10.
//   Throughput is one item per cycle while rsp_o does not stall: the four taps
//   come from four interleaved banks read in the same cycle, and the evaluator
//   is a five-stage pipeline. Each result is registered through bank read,
//   coefficients, three multiply stages and round/saturate.
//   A stall on rsp_o freezes the full stages; empty stages still fill, so up to
//   six lookups can be held. Reset empties the pipeline; table contents are not
//   cleared and must be written before they are read.

module wavetable_cubic_interp_lookup_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [wtci_pkg::CFG_W-1:0] cfg_wdata_i,
  wtci_req_if.sink                   req_i,
  wtci_rsp_if.source                 rsp_o
);
  import wtci_pkg::*;

  logic     tap_valid;
  logic     tap_ready;
  tap_set_t taps;

  // table store and address decode
  wtci_fetch u_fetch (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_i),
    .tap_valid_o(tap_valid),
    .tap_ready_i(tap_ready),
    .taps_o     (taps)
  );

  // interpolation pipeline
  wtci_eval u_eval (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tap_valid_i(tap_valid),
    .tap_ready_o(tap_ready),
    .taps_i     (taps),
    .rsp_o      (rsp_o)
  );

endmodule
